// ===== src/gf173_pkg.sv =====
`timescale 1ns / 1ps
package gf173_pkg;
    localparam int Deg = 173;
    // reduction taps below x^173: x^10 + x^2 + x + 1
    localparam logic [172:0] RedPoly = 173'h405 | 173'h2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_MUL = 3'd1, OP_SQR = 3'd2, OP_POW = 3'd3,
        OP_INV = 3'd4, OP_TRC = 3'd5, OP_ISZ = 3'd6, OP_ISO = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCHED, ST_MUL, ST_DONE
    } t_state;

    // one step of the bit-serial multiplier: acc = acc*x mod p, then add b if bit set
    function automatic logic [172:0] mul_step(input logic [172:0] acc,
            input logic [172:0] b, input logic bit_in);
        logic [172:0] sh;
        sh = {acc[171:0], 1'b0} ^ (acc[172] ? RedPoly : 173'd0);
        return sh ^ (bit_in ? b : 173'd0);
    endfunction
endpackage

// ===== src/gf2_173_field_alu_unit.sv =====
`timescale 1ns / 1ps
// GF(2^173) field arithmetic unit, polynomial basis, modulus x^173+x^10+x^2+x+1.
// Input channel (i_valid/o_ready) takes one item: opcode, operands a and b
// in three words each, and a 64-bit exponent. Output channel (o_valid/i_ready)
// gives one result item per input item: three result words and a flag.
// All products run on one bit-serial multiplier, one bit of the multiplier
// operand per cycle, with a scheduling step before each field multiplication.
// Add and the zero and one tests skip the multiplier; multiply and square use
// it once; power squares once per exponent bit up to the highest set one and
// multiplies once per set bit; inverse takes 343 multiplications; trace takes
// 172 squarings. One item is in flight at a time, and o_ready rises only in
// the cycle after a result is taken.
// Reset clears the controller; the result holds in the output register
// while the receiver stalls, and no new item is taken until it is delivered.
module gf2_173_field_alu_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_a_word0,
    input  logic [63:0] i_a_word1,
    input  logic [44:0] i_a_word2,
    input  logic [63:0] i_b_word0,
    input  logic [63:0] i_b_word1,
    input  logic [44:0] i_b_word2,
    input  logic [63:0] i_exponent,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_r_word0,
    output logic [63:0] o_r_word1,
    output logic [44:0] o_r_word2,
    output logic        o_flag
);
    gf173_pkg::t_state r_state, n_state;
    gf173_pkg::t_op    r_op;
    logic [172:0] r_base, r_acc, r_sum;   // working registers
    logic [172:0] r_m_a, r_m_b, r_prod;   // multiplier: shift operand, addend, product
    logic [7:0]   r_cnt;                  // multiplier bit count
    logic [63:0]  r_exp;
    logic [7:0]   r_iter;                 // loop count for inverse and trace
    logic         r_phase;                // inverse: 0 square step, 1 accumulate
    logic [172:0] r_res;
    logic         r_flag;

    logic [172:0] w_a, w_b;
    logic         w_sched_done;
    logic         w_start;
    logic [172:0] w_ma, w_mb;

    assign w_a = {i_a_word2, i_a_word1, i_a_word0};
    assign w_b = {i_b_word2, i_b_word1, i_b_word0};

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gf173_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gf173_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == gf173_pkg::OP_ADD || i_req_type == gf173_pkg::OP_ISZ
                        || i_req_type == gf173_pkg::OP_ISO)
                        n_state = gf173_pkg::ST_DONE;
                    else
                        n_state = gf173_pkg::ST_SCHED;
                end
            end
            gf173_pkg::ST_SCHED: n_state = gf173_pkg::ST_MUL;
            gf173_pkg::ST_MUL: begin
                if (r_cnt == 8'd0) n_state = gf173_pkg::ST_SCHED;
            end
            gf173_pkg::ST_DONE: begin
                if (i_ready) n_state = gf173_pkg::ST_IDLE;
            end
            default: n_state = gf173_pkg::ST_IDLE;
        endcase
        // scheduler may finish instead of starting a multiply
        if (r_state == gf173_pkg::ST_SCHED && w_sched_done) n_state = gf173_pkg::ST_DONE;
    end

    // scheduler decision: what to multiply next, or done
    always_comb begin
        w_sched_done = 1'b0;
        w_start = 1'b0;
        w_ma = r_base;
        w_mb = r_base;
        unique case (r_op)
            gf173_pkg::OP_MUL, gf173_pkg::OP_SQR: begin
                // r_phase 1 means product already in r_prod
                if (r_phase) w_sched_done = 1'b1;
                else begin
                    w_start = 1'b1; w_ma = r_base; w_mb = r_acc;
                end
            end
            gf173_pkg::OP_POW: begin
                if (!r_phase) begin
                    if (r_exp == 64'd0) w_sched_done = 1'b1;
                    else if (r_exp[0]) begin
                        w_start = 1'b1; w_ma = r_acc; w_mb = r_base;
                    end else begin
                        w_start = 1'b1;
                    end
                end else begin
                    w_start = 1'b1;
                end
            end
            gf173_pkg::OP_INV: begin
                if (r_iter == 8'd171) begin
                    if (r_phase) w_sched_done = 1'b1;
                    else begin
                        w_start = 1'b1; w_ma = r_acc; w_mb = r_acc;
                    end
                end else if (!r_phase) w_start = 1'b1;
                else begin
                    w_start = 1'b1; w_ma = r_acc; w_mb = r_base;
                end
            end
            gf173_pkg::OP_TRC: begin
                if (r_iter == 8'd172) w_sched_done = 1'b1;
                else w_start = 1'b1;
            end
            default: w_sched_done = 1'b1;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= gf173_pkg::OP_ADD;
            r_cnt <= 8'd0;
            r_phase <= 1'b0;
            r_iter <= 8'd0;
        end else begin
            unique case (r_state)
                gf173_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_op    <= gf173_pkg::t_op'(i_req_type);
                        r_base  <= w_a;
                        r_acc   <= (i_req_type == gf173_pkg::OP_SQR) ? w_a :
                                   (i_req_type == gf173_pkg::OP_MUL) ? w_b :
                                   (i_req_type == gf173_pkg::OP_POW) ? 173'd1 : w_a;
                        r_sum   <= w_a;
                        r_exp   <= i_exponent;
                        r_iter  <= 8'd0;
                        r_phase <= 1'b0;
                        r_flag  <= 1'b0;
                        r_res   <= 173'd0;
                        if (i_req_type == gf173_pkg::OP_ADD) r_res <= w_a ^ w_b;
                        if (i_req_type == gf173_pkg::OP_ISZ) r_flag <= (w_a == 173'd0);
                        if (i_req_type == gf173_pkg::OP_ISO) r_flag <= (w_a == 173'd1);
                    end
                end
                gf173_pkg::ST_SCHED: begin
                    if (w_start) begin
                        r_m_a  <= w_ma;
                        r_m_b  <= w_mb;
                        r_prod <= 173'd0;
                        r_cnt  <= 8'(gf173_pkg::Deg - 1);
                    end else begin
                        unique case (r_op)
                            gf173_pkg::OP_MUL, gf173_pkg::OP_SQR,
                            gf173_pkg::OP_INV: r_res <= r_prod;
                            gf173_pkg::OP_POW: r_res <= r_acc;
                            gf173_pkg::OP_TRC: r_flag <= r_sum[0];
                            default: r_res <= r_res;
                        endcase
                    end
                end
                gf173_pkg::ST_MUL: begin
                    // msb first: Horner over the bits of r_m_a
                    r_prod <= gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                    r_m_a  <= {r_m_a[171:0], 1'b0};
                    if (r_cnt != 8'd0) r_cnt <= r_cnt - 8'd1;
                    else begin
                        // write back the finished product
                        unique case (r_op)
                            gf173_pkg::OP_MUL, gf173_pkg::OP_SQR: r_phase <= 1'b1;
                            gf173_pkg::OP_POW: begin
                                if (!r_phase && r_exp[0]) begin
                                    r_acc <= gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                                    r_phase <= 1'b1;
                                end else begin
                                    r_base <= gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                                    r_exp <= {1'b0, r_exp[63:1]};
                                    r_phase <= 1'b0;
                                end
                            end
                            gf173_pkg::OP_INV: begin
                                if (r_iter == 8'd171) r_phase <= 1'b1;
                                else if (!r_phase) begin
                                    r_base <= gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                                    r_phase <= 1'b1;
                                end else begin
                                    r_acc <= gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                                    r_phase <= 1'b0;
                                    r_iter <= r_iter + 8'd1;
                                end
                            end
                            gf173_pkg::OP_TRC: begin
                                r_base <= gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                                r_sum <= r_sum ^ gf173_pkg::mul_step(r_prod, r_m_b, r_m_a[172]);
                                r_iter <= r_iter + 8'd1;
                            end
                            default: r_phase <= r_phase;
                        endcase
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // handshake and result outputs
    always_comb begin
        o_ready   = (r_state == gf173_pkg::ST_IDLE);
        o_valid   = (r_state == gf173_pkg::ST_DONE);
        o_r_word0 = r_res[63:0];
        o_r_word1 = r_res[127:64];
        o_r_word2 = r_res[172:128];
        o_flag    = r_flag;
    end
endmodule
